// File: hw/rtl/efv_pkg.sv
// ----------------------------------------------------------------------------
// efv_pkg
// shared types, codes and checksum helper for the frame validator
// ----------------------------------------------------------------------------
`default_nettype none

package efv_pkg;

  localparam int unsigned MaxFrameBytes = 16384;
  localparam int unsigned LenW          = 15;
  localparam logic [LenW-1:0] MAX_LEN   = LenW'(MaxFrameBytes);

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_ARP  = 16'h0806;
  localparam logic [7:0]  PROT_TCP = 8'd6;
  localparam logic [7:0]  PROT_UDP = 8'd17;

  typedef enum logic [4:0] {
    ST_OK            = 5'd0,
    ST_ETH_SHORT     = 5'd1,
    ST_BAD_ETYPE     = 5'd2,
    ST_ARP_TRUNC     = 5'd3,
    ST_ARP_HTYPE     = 5'd4,
    ST_ARP_PTYPE     = 5'd5,
    ST_ARP_HLEN      = 5'd6,
    ST_ARP_PLEN      = 5'd7,
    ST_ARP_OPCODE    = 5'd8,
    ST_ARP_ADDR      = 5'd9,
    ST_ARP_BCAST     = 5'd10,
    ST_IP_SHORT      = 5'd11,
    ST_IP_VERSION    = 5'd12,
    ST_IP_IHL        = 5'd13,
    ST_IP_HDR_LONG   = 5'd14,
    ST_IP_TLEN_SMALL = 5'd15,
    ST_IP_TLEN_LONG  = 5'd16,
    ST_IP_CSUM       = 5'd17,
    ST_L4_UNSUP      = 5'd18,
    ST_TCP_SHORT     = 5'd19,
    ST_TCP_OFFSET    = 5'd20,
    ST_TCP_HDR_LONG  = 5'd21,
    ST_TCP_CSUM      = 5'd22,
    ST_UDP_SHORT     = 5'd23,
    ST_UDP_LEN_SMALL = 5'd24,
    ST_UDP_LEN_LONG  = 5'd25,
    ST_UDP_CSUM      = 5'd26,
    ST_TOO_LONG      = 5'd27
  } status_e;

  typedef enum logic [1:0] {
    KIND_ARP   = 2'd0,
    KIND_IPV4  = 2'd1,
    KIND_OTHER = 2'd2
  } kind_e;

  // per-frame summary handed from parser to checker
  typedef struct packed {
    logic [LenW-1:0] len;
    logic [15:0]     etype;
    logic [3:0]      arp_fault;
    logic            tgt_ones;
    logic [7:0]      vihl;
    logic [15:0]     tlen;
    logic [7:0]      prot;
    logic [15:0]     ip_sum;
    logic [15:0]     ip_rcv;
    logic [15:0]     l4_sum;
    logic [15:0]     l4_rcv;
    logic [15:0]     udp_len;
    logic [3:0]      tcp_words;
  } snap_t;

  localparam int unsigned SnapW = $bits(snap_t);

  // end-around carry add
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/efv_front.sv
// ----------------------------------------------------------------------------
// efv_front
// byte parser: captures header fields and running checksums per frame
// ----------------------------------------------------------------------------
`default_nettype none

module efv_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [7:0]         data_byte_i,
  input  wire logic               last_byte_i,
  output efv_pkg::snap_t          snap_o,
  output logic                    snap_valid_o
);

  logic [efv_pkg::LenW-1:0] bc_q, bc_d;
  logic [15:0] eth_q, eth_d;
  logic [3:0]  af_q, af_d;
  logic        tgt_q, tgt_d;
  logic [7:0]  vihl_q, vihl_d;
  logic [15:0] tl_q, tl_d;
  logic [7:0]  prot_q, prot_d;
  logic [15:0] ips_q, ips_d;
  logic [15:0] ipr_q, ipr_d;
  logic [15:0] l4_q, l4_d;
  logic [15:0] l4r_q, l4r_d;
  logic [15:0] udp_q, udp_d;
  logic [3:0]  tw_q, tw_d;
  logic [7:0]  pend_q, pend_d;

  logic [efv_pkg::LenW-1:0] i;
  logic [efv_pkg::LenW-1:0] rel;
  logic [15:0] word;
  logic        odd;
  logic [5:0]  hl;
  logic [6:0]  o;
  logic [15:0] l4a;
  logic [15:0] tcp_lim;
  logic [4:0]  cs;
  logic [15:0] rel1;
  logic        is_l4, incl0, incl1;

  always_comb begin
    bc_d = bc_q; eth_d = eth_q; af_d = af_q; tgt_d = tgt_q; vihl_d = vihl_q;
    tl_d = tl_q; prot_d = prot_q; ips_d = ips_q; ipr_d = ipr_q; l4_d = l4_q;
    l4r_d = l4r_q; udp_d = udp_q; tw_d = tw_q; pend_d = pend_q;
    i = bc_q;
    word = {pend_q, data_byte_i};
    odd = i[0];
    hl = '0; o = '0; l4a = l4_q; tcp_lim = '0; cs = '0; rel = '0; rel1 = '0;
    is_l4 = 1'b0; incl0 = 1'b0; incl1 = 1'b0;
    if (i < efv_pkg::MAX_LEN) begin
      if (!odd) pend_d = data_byte_i;
      if (i == 15'd13) eth_d = word;
      // arp field checks
      if (i >= 15'd14 && eth_q == efv_pkg::ETH_ARP) begin
        if (i == 15'd15 && word != 16'd1 && af_d == 4'd0) af_d = 4'(efv_pkg::ST_ARP_HTYPE);
        if (i == 15'd17 && word != efv_pkg::ETH_IPV4 && af_d == 4'd0)
          af_d = 4'(efv_pkg::ST_ARP_PTYPE);
        if (i == 15'd18 && data_byte_i != 8'd6 && af_d == 4'd0)
          af_d = 4'(efv_pkg::ST_ARP_HLEN);
        if (i == 15'd19 && data_byte_i != 8'd4 && af_d == 4'd0)
          af_d = 4'(efv_pkg::ST_ARP_PLEN);
        if (i == 15'd21) begin
          if (word != 16'd1 && word != 16'd2 && af_d == 4'd0)
            af_d = 4'(efv_pkg::ST_ARP_OPCODE);
          if (word != 16'd2) tgt_d = 1'b0;
        end
        if (i >= 15'd32 && i <= 15'd37 && data_byte_i != 8'hFF) tgt_d = 1'b0;
      end
      // ipv4 header and l4 accumulation
      if (i >= 15'd14 && eth_q == efv_pkg::ETH_IPV4) begin
        if (i == 15'd14) vihl_d = data_byte_i;
        hl = {vihl_d[3:0], 2'b00};
        if (odd && i >= 15'd15 && i < (15'd14 + 15'(hl)) && i != 15'd25)
          ips_d = efv_pkg::oc_add(ips_q, word);
        if (i == 15'd25) ipr_d = word;
        if (i == 15'd17) tl_d = word;
        if (i == 15'd23) prot_d = data_byte_i;
        if (odd && i >= 15'd27 && i <= 15'd33) l4a = efv_pkg::oc_add(l4a, word);
        o = 7'd14 + 7'(hl);
        is_l4 = (prot_d == efv_pkg::PROT_TCP) || (prot_d == efv_pkg::PROT_UDP);
        if (i >= 15'(o) && is_l4) begin
          rel = i - 15'(o);
          rel1 = 16'(rel) + 16'd1;
          cs = (prot_d == efv_pkg::PROT_TCP) ? 5'd16 : 5'd6;
          if (prot_d == efv_pkg::PROT_TCP && rel == 15'd12) tw_d = data_byte_i[7:4];
          if (prot_d == efv_pkg::PROT_UDP && rel == 15'd5) udp_d = word;
          tcp_lim = tl_d - 16'(hl);
          if (prot_d == efv_pkg::PROT_TCP) begin
            incl0 = 16'(rel) < tcp_lim;
            incl1 = rel1 < tcp_lim;
          end else begin
            incl0 = (rel < 15'd8) || (16'(rel) < udp_d);
            incl1 = (rel1 < 16'd8) || (rel1 < udp_d);
          end
          if (odd) begin
            if (rel == 15'(cs) + 15'd1) l4r_d = word;
            else if (incl0) l4a = efv_pkg::oc_add(l4a, word);
          end else if (rel != 15'(cs) && incl0 && !incl1) begin
            l4a = efv_pkg::oc_add(l4a, {data_byte_i, 8'h00});
          end
        end
        l4_d = l4a;
      end
    end
    if (bc_q <= efv_pkg::MAX_LEN) bc_d = bc_q + 15'd1;
  end

  always_comb begin
    snap_o.len       = bc_d;
    snap_o.etype     = eth_d;
    snap_o.arp_fault = af_d;
    snap_o.tgt_ones  = tgt_d;
    snap_o.vihl      = vihl_d;
    snap_o.tlen      = tl_d;
    snap_o.prot      = prot_d;
    snap_o.ip_sum    = ips_d;
    snap_o.ip_rcv    = ipr_d;
    snap_o.l4_sum    = l4_d;
    snap_o.l4_rcv    = l4r_d;
    snap_o.udp_len   = udp_d;
    snap_o.tcp_words = tw_d;
    snap_valid_o     = accept_i && last_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q <= '0; eth_q <= '0; af_q <= '0; tgt_q <= 1'b1; vihl_q <= '0; tl_q <= '0;
      prot_q <= '0; ips_q <= '0; ipr_q <= '0; l4_q <= '0; l4r_q <= '0; udp_q <= '0;
      tw_q <= '0; pend_q <= '0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        // frame done, start clean
        bc_q <= '0; eth_q <= '0; af_q <= '0; tgt_q <= 1'b1; vihl_q <= '0; tl_q <= '0;
        prot_q <= '0; ips_q <= '0; ipr_q <= '0; l4_q <= '0; l4r_q <= '0; udp_q <= '0;
        tw_q <= '0; pend_q <= '0;
      end else begin
        bc_q <= bc_d; eth_q <= eth_d; af_q <= af_d; tgt_q <= tgt_d; vihl_q <= vihl_d;
        tl_q <= tl_d; prot_q <= prot_d; ips_q <= ips_d; ipr_q <= ipr_d; l4_q <= l4_d;
        l4r_q <= l4r_d; udp_q <= udp_d; tw_q <= tw_d; pend_q <= pend_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/efv_fifo.sv
// ----------------------------------------------------------------------------
// efv_fifo
// small queue of frame summaries between parser and checker
// ----------------------------------------------------------------------------
`default_nettype none

module efv_fifo (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      wr_i,
  input  wire logic [efv_pkg::SnapW-1:0] wdata_i,
  input  wire logic                      rd_i,
  output logic [efv_pkg::SnapW-1:0]      rdata_o,
  output logic                           full_o,
  output logic                           empty_o
);

  logic [efv_pkg::SnapW-1:0] mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;

  assign full_o  = cnt_q == 3'd4;
  assign empty_o = cnt_q == 3'd0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + 2'd1;
      if (rd_i) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'b00, wr_i} - {2'b00, rd_i};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_i && full_o)) else $error("summary queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_i && empty_o)) else $error("summary queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("summary queue count out of range");

endmodule

`default_nettype wire

// File: hw/rtl/efv_back.sv
// ----------------------------------------------------------------------------
// efv_back
// checker: ordered checks on a frame summary, registered result
// ----------------------------------------------------------------------------
`default_nettype none

module efv_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  efv_pkg::snap_t                  snap_i,
  input  wire logic                       snap_avail_i,
  output logic                            snap_take_o,
  input  wire logic                       pop_i,
  output logic                            valid_o,
  output logic [4:0]                      status_o,
  output logic [1:0]                      kind_o,
  output logic [efv_pkg::LenW-1:0]        len_o
);

  logic                     valid_q;
  logic [4:0]               status_q;
  logic [1:0]               kind_q;
  logic [efv_pkg::LenW-1:0] len_q;

  efv_pkg::status_e         st;
  efv_pkg::kind_e           kd;
  logic [efv_pkg::LenW-1:0] ln;
  logic [16:0] len17, hl17, o17, dlen17;
  logic [5:0]  hl;
  logic [15:0] tcp_s, udp_s, seg;

  always_comb begin
    len17  = 17'(snap_i.len);
    hl     = {snap_i.vihl[3:0], 2'b00};
    hl17   = 17'(hl);
    o17    = 17'd14 + hl17;
    dlen17 = 17'(snap_i.tcp_words) << 2;
    seg    = snap_i.tlen - 16'(hl);
    tcp_s  = efv_pkg::oc_add(efv_pkg::oc_add(snap_i.l4_sum, 16'(snap_i.prot)), seg);
    udp_s  = efv_pkg::oc_add(efv_pkg::oc_add(snap_i.l4_sum, 16'(snap_i.prot)),
                             snap_i.udp_len);
    ln = snap_i.len;
    st = efv_pkg::ST_OK;
    if (snap_i.len > efv_pkg::MAX_LEN) begin
      st = efv_pkg::ST_TOO_LONG;
      ln = efv_pkg::MAX_LEN;
    end else if (len17 < 17'd14) begin
      st = efv_pkg::ST_ETH_SHORT;
    end else if (snap_i.etype == efv_pkg::ETH_ARP) begin
      if (len17 < 17'd22) st = efv_pkg::ST_ARP_TRUNC;
      else if (snap_i.arp_fault != 4'd0) st = efv_pkg::status_e'(5'(snap_i.arp_fault));
      else if (len17 < 17'd42) st = efv_pkg::ST_ARP_ADDR;
      else if (snap_i.tgt_ones) st = efv_pkg::ST_ARP_BCAST;
    end else if (snap_i.etype != efv_pkg::ETH_IPV4) begin
      st = efv_pkg::ST_BAD_ETYPE;
    end else if (len17 < 17'd34) begin
      st = efv_pkg::ST_IP_SHORT;
    end else if (snap_i.vihl[7:4] != 4'd4) begin
      st = efv_pkg::ST_IP_VERSION;
    end else if (snap_i.vihl[3:0] < 4'd5) begin
      st = efv_pkg::ST_IP_IHL;
    end else if (len17 < o17) begin
      st = efv_pkg::ST_IP_HDR_LONG;
    end else if (17'(snap_i.tlen) < hl17) begin
      st = efv_pkg::ST_IP_TLEN_SMALL;
    end else if (17'(snap_i.tlen) > len17 - 17'd14) begin
      st = efv_pkg::ST_IP_TLEN_LONG;
    end else if (~snap_i.ip_sum != snap_i.ip_rcv) begin
      st = efv_pkg::ST_IP_CSUM;
    end else if (snap_i.prot == efv_pkg::PROT_TCP) begin
      if (len17 < o17 + 17'd20) st = efv_pkg::ST_TCP_SHORT;
      else if (snap_i.tcp_words < 4'd5) st = efv_pkg::ST_TCP_OFFSET;
      else if (len17 < o17 + dlen17) st = efv_pkg::ST_TCP_HDR_LONG;
      else if (~tcp_s != snap_i.l4_rcv) st = efv_pkg::ST_TCP_CSUM;
    end else if (snap_i.prot == efv_pkg::PROT_UDP) begin
      if (len17 < o17 + 17'd8) st = efv_pkg::ST_UDP_SHORT;
      else if (snap_i.udp_len < 16'd8) st = efv_pkg::ST_UDP_LEN_SMALL;
      else if (17'(snap_i.udp_len) > len17 - o17) st = efv_pkg::ST_UDP_LEN_LONG;
      else if (snap_i.l4_rcv != 16'd0 && ~udp_s != snap_i.l4_rcv)
        st = efv_pkg::ST_UDP_CSUM;
    end else begin
      st = efv_pkg::ST_L4_UNSUP;
    end
    if (len17 < 17'd14) kd = efv_pkg::KIND_OTHER;
    else if (snap_i.etype == efv_pkg::ETH_ARP) kd = efv_pkg::KIND_ARP;
    else if (snap_i.etype == efv_pkg::ETH_IPV4) kd = efv_pkg::KIND_IPV4;
    else kd = efv_pkg::KIND_OTHER;
  end

  assign snap_take_o = snap_avail_i && (!valid_q || pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (snap_take_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_take_o) begin
      status_q <= st;
      kind_q   <= kd;
      len_q    <= ln;
    end
  end

  assign valid_o  = valid_q;
  assign status_o = status_q;
  assign kind_o   = kind_q;
  assign len_o    = len_q;

endmodule

`default_nettype wire

// File: hw/rtl/eth_arp_ipv4_l4_frame_validator.sv
// ----------------------------------------------------------------------------
// eth_arp_ipv4_l4_frame_validator
// streaming ethernet / arp / ipv4 / tcp / udp frame checker
// ----------------------------------------------------------------------------
// input channel: one frame byte per transaction (push, full), last_byte_i set
//   on the final byte; bytes are taken one per cycle while full is low
// result channel: one status transaction per frame (empty, pop), carrying the
//   status code, frame kind and saturated frame length
// result path: taking a frame's last byte writes its summary into the queue,
//   and the checker registers its result when the result register is free or being popped
// throughput: 1 byte per cycle while full is low; the parser handles each byte
//   with a compare and up to two end-around adds
// a 4-deep summary queue sits between the parser and the checker; full only
//   rises when 4 frame summaries plus the result register are all waiting,
//   i.e. when the result side has stalled for several whole frames
// reset clears the parser state, the queue and the result register
// bytes past the maximum frame size are not parsed, and the byte count stops
//   just above that size; such a frame reports frame too long
// ----------------------------------------------------------------------------
`default_nettype none

module eth_arp_ipv4_l4_frame_validator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic                          last_byte_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [4:0]                         status_o,
  output logic [1:0]                         frame_kind_o,
  output logic [efv_pkg::LenW-1:0]           frame_length_o
);

  logic                      accept;
  efv_pkg::snap_t            snap_wr;
  efv_pkg::snap_t            snap_rd;
  logic                      snap_wr_en;
  logic [efv_pkg::SnapW-1:0] rd_bits;
  logic                      q_full, q_empty, q_take;
  logic                      res_valid;

  // byte transaction happens when the summary queue has room
  assign accept = push && !full;
  assign full   = q_full;

  efv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .snap_o       (snap_wr),
    .snap_valid_o (snap_wr_en)
  );

  efv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (snap_wr_en),
    .wdata_i (snap_wr),
    .rd_i    (q_take),
    .rdata_o (rd_bits),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign snap_rd = efv_pkg::snap_t'(rd_bits);

  efv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_i       (snap_rd),
    .snap_avail_i (!q_empty),
    .snap_take_o  (q_take),
    .pop_i        (pop && !empty),
    .valid_o      (res_valid),
    .status_o     (status_o),
    .kind_o       (frame_kind_o),
    .len_o        (frame_length_o)
  );

  assign empty = !res_valid;

endmodule

`default_nettype wire

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// byte-stream testbench for the ethernet / arp / ipv4 / l4 frame validator
// ----------------------------------------------------------------------------
// frames are built as byte lists (directed corner frames, then mostly
// well-formed arp, ipv4, tcp and udp frames with random content and a share
// of corrupted or noise frames), fed one byte per push transaction, and every
// byte is also run through a behavioral predictor; each predicted status
// transaction is queued and compared with what the block pops
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_t;

  typedef struct {
    logic [4:0]               status;
    logic [1:0]               kind;
    logic [efv_pkg::LenW-1:0] len;
  } verdict_t;

  logic clk, rst_n;
  logic push_r, last_r, pop_r;
  logic [7:0] data_r;
  wire full_w, empty_w;
  wire [4:0] status_w;
  wire [1:0] kind_w;
  wire [efv_pkg::LenW-1:0] len_w;

  eth_arp_ipv4_l4_frame_validator uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push           (push_r),
    .full           (full_w),
    .data_byte_i    (data_r),
    .last_byte_i    (last_r),
    .empty          (empty_w),
    .pop            (pop_r),
    .status_o       (status_w),
    .frame_kind_o   (kind_w),
    .frame_length_o (len_w)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  byte_t    byte_q[$];
  verdict_t verdict_q[$];
  int       mismatches = 0;
  int       frames_seen = 0;
  int       bytes_sent = 0;
  bit       stim_done = 0;
  bit       sender_hold = 0;
  int       hold_off_cycles = 0;
  bit       in_acc = 0;

  // ---------------- predictor state ----------------
  int unsigned p_cnt;
  logic [15:0] p_etype;
  logic [3:0]  p_arp_fault;
  bit          p_tgt_ones;
  logic [7:0]  p_vihl, p_prot, p_pend;
  logic [15:0] p_tlen, p_ipsum, p_iprcv, p_l4sum, p_l4rcv, p_udplen;
  logic [3:0]  p_tcpw;

  function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + 16'(s[16]);
  endfunction

  task automatic clear_parse();
    p_cnt = 0; p_etype = 0; p_arp_fault = 0; p_tgt_ones = 1; p_vihl = 0;
    p_tlen = 0; p_prot = 0; p_ipsum = 0; p_iprcv = 0; p_l4sum = 0;
    p_l4rcv = 0; p_udplen = 0; p_tcpw = 0; p_pend = 0;
  endtask

  function automatic int unsigned ip_hdr_bytes();
    return int'(p_vihl[3:0]) * 4;
  endfunction

  function automatic bit in_segment(int unsigned rel);
    logic [15:0] seg;
    seg = p_tlen - 16'(ip_hdr_bytes());
    if (p_prot == efv_pkg::PROT_TCP) return rel < seg;
    if (p_prot == efv_pkg::PROT_UDP) return rel < 8 || rel < p_udplen;
    return 0;
  endfunction

  task automatic parse_arp(int unsigned i, logic [7:0] b, logic [15:0] w);
    if (i == 15 && w != 16'd1 && p_arp_fault == 0)
      p_arp_fault = 4'(efv_pkg::ST_ARP_HTYPE);
    if (i == 17 && w != efv_pkg::ETH_IPV4 && p_arp_fault == 0)
      p_arp_fault = 4'(efv_pkg::ST_ARP_PTYPE);
    if (i == 18 && b != 8'd6 && p_arp_fault == 0)
      p_arp_fault = 4'(efv_pkg::ST_ARP_HLEN);
    if (i == 19 && b != 8'd4 && p_arp_fault == 0)
      p_arp_fault = 4'(efv_pkg::ST_ARP_PLEN);
    if (i == 21) begin
      if (w != 16'd1 && w != 16'd2 && p_arp_fault == 0)
        p_arp_fault = 4'(efv_pkg::ST_ARP_OPCODE);
      if (w != 16'd2) p_tgt_ones = 0;
    end
    if (i >= 32 && i <= 37 && b != 8'hFF) p_tgt_ones = 0;
  endtask

  task automatic parse_ip(int unsigned i, logic [7:0] b, logic [15:0] w, bit odd);
    int unsigned hl, o, rel, cs;
    if (i == 14) p_vihl = b;
    hl = ip_hdr_bytes();
    if (odd && i >= 15 && i < 14 + hl && i != 25) p_ipsum = ones_add(p_ipsum, w);
    if (i == 25) p_iprcv = w;
    if (i == 17) p_tlen = w;
    if (i == 23) p_prot = b;
    if (odd && i >= 27 && i <= 33) p_l4sum = ones_add(p_l4sum, w);
    o = 14 + hl;
    if (i >= o && (p_prot == efv_pkg::PROT_TCP || p_prot == efv_pkg::PROT_UDP)) begin
      rel = i - o;
      cs = (p_prot == efv_pkg::PROT_TCP) ? 16 : 6;
      if (p_prot == efv_pkg::PROT_TCP && rel == 12) p_tcpw = b[7:4];
      if (p_prot == efv_pkg::PROT_UDP && rel == 5) p_udplen = w;
      if (odd) begin
        if (rel == cs + 1) p_l4rcv = w;
        else if (in_segment(rel)) p_l4sum = ones_add(p_l4sum, w);
      end else if (rel != cs && in_segment(rel) && !in_segment(rel + 1)) begin
        p_l4sum = ones_add(p_l4sum, {b, 8'h00});
      end
    end
  endtask

  function automatic logic [4:0] judge(int unsigned n);
    int unsigned hl, o;
    logic [15:0] s;
    if (n < 14) return efv_pkg::ST_ETH_SHORT;
    if (p_etype == efv_pkg::ETH_ARP) begin
      if (n < 22) return efv_pkg::ST_ARP_TRUNC;
      if (p_arp_fault != 0) return 5'(p_arp_fault);
      if (n < 42) return efv_pkg::ST_ARP_ADDR;
      return p_tgt_ones ? efv_pkg::ST_ARP_BCAST : efv_pkg::ST_OK;
    end
    if (p_etype != efv_pkg::ETH_IPV4) return efv_pkg::ST_BAD_ETYPE;
    if (n < 34) return efv_pkg::ST_IP_SHORT;
    if (p_vihl[7:4] != 4'd4) return efv_pkg::ST_IP_VERSION;
    if (p_vihl[3:0] < 4'd5) return efv_pkg::ST_IP_IHL;
    hl = ip_hdr_bytes();
    if (n < 14 + hl) return efv_pkg::ST_IP_HDR_LONG;
    if (p_tlen < hl) return efv_pkg::ST_IP_TLEN_SMALL;
    if (p_tlen > n - 14) return efv_pkg::ST_IP_TLEN_LONG;
    if (~p_ipsum != p_iprcv) return efv_pkg::ST_IP_CSUM;
    o = 14 + hl;
    if (p_prot == efv_pkg::PROT_TCP) begin
      if (n < o + 20) return efv_pkg::ST_TCP_SHORT;
      if (p_tcpw < 4'd5) return efv_pkg::ST_TCP_OFFSET;
      if (n < o + p_tcpw * 4) return efv_pkg::ST_TCP_HDR_LONG;
      s = ones_add(ones_add(p_l4sum, 16'(p_prot)), p_tlen - 16'(hl));
      return (~s != p_l4rcv) ? efv_pkg::ST_TCP_CSUM : efv_pkg::ST_OK;
    end
    if (p_prot == efv_pkg::PROT_UDP) begin
      if (n < o + 8) return efv_pkg::ST_UDP_SHORT;
      if (p_udplen < 16'd8) return efv_pkg::ST_UDP_LEN_SMALL;
      if (p_udplen > n - o) return efv_pkg::ST_UDP_LEN_LONG;
      if (p_l4rcv == 0) return efv_pkg::ST_OK;
      s = ones_add(ones_add(p_l4sum, 16'(p_prot)), p_udplen);
      return (~s != p_l4rcv) ? efv_pkg::ST_UDP_CSUM : efv_pkg::ST_OK;
    end
    return efv_pkg::ST_L4_UNSUP;
  endfunction

  // advance the predictor by one accepted byte
  task automatic predict_byte(logic [7:0] b, logic last);
    int unsigned i;
    bit odd;
    logic [15:0] w;
    verdict_t v;
    i = p_cnt;
    if (i < efv_pkg::MaxFrameBytes) begin
      odd = i[0];
      w = {p_pend, b};
      if (!odd) p_pend = b;
      if (i == 13) p_etype = w;
      if (i >= 14 && p_etype == efv_pkg::ETH_ARP) parse_arp(i, b, w);
      if (i >= 14 && p_etype == efv_pkg::ETH_IPV4) parse_ip(i, b, w, odd);
    end
    if (p_cnt <= efv_pkg::MaxFrameBytes) p_cnt++;
    if (!last) return;
    if (p_cnt > efv_pkg::MaxFrameBytes) begin
      v.status = efv_pkg::ST_TOO_LONG;
      v.len = efv_pkg::MAX_LEN;
    end else begin
      v.status = judge(p_cnt);
      v.len = efv_pkg::LenW'(p_cnt);
    end
    if (p_cnt < 14) v.kind = efv_pkg::KIND_OTHER;
    else if (p_etype == efv_pkg::ETH_ARP) v.kind = efv_pkg::KIND_ARP;
    else if (p_etype == efv_pkg::ETH_IPV4) v.kind = efv_pkg::KIND_IPV4;
    else v.kind = efv_pkg::KIND_OTHER;
    verdict_q = {verdict_q, v};
    clear_parse();
  endtask

  // ---------------- frame builders ----------------
  typedef logic [7:0] frame_t[$];

  function automatic logic [15:0] sum_words(frame_t f, int s, int n);
    logic [15:0] a;
    a = 0;
    for (int k = 0; k < n; k += 2)
      a = ones_add(a, {f[s+k], (k + 1 < n) ? f[s+k+1] : 8'h00});
    return a;
  endfunction

  function automatic frame_t eth_head(logic [15:0] et);
    frame_t f;
    for (int k = 0; k < 12; k++) f = {f, 8'($urandom)};
    f = {f, et[15:8]};
    f = {f, et[7:0]};
    return f;
  endfunction

  function automatic frame_t arp_frame(logic [15:0] op, bit bcast_tgt);
    frame_t f;
    f = eth_head(efv_pkg::ETH_ARP);
    f = {f, 8'h00, 8'h01};
    f = {f, 8'h08, 8'h00};
    f = {f, 8'd6, 8'd4};
    f = {f, op[15:8], op[7:0]};
    for (int k = 22; k < 32; k++) f = {f, 8'($urandom)};
    for (int k = 32; k < 38; k++) f = {f, bcast_tgt ? 8'hFF : 8'($urandom)};
    for (int k = 38; k < 42; k++) f = {f, 8'($urandom)};
    return f;
  endfunction

  // well-formed ipv4 with tcp/udp/other payload; pad adds trailing bytes
  function automatic frame_t ip_frame(logic [7:0] prot, int ihl, int seg, int pad,
                                      bit zero_udp_csum);
    frame_t f;
    int o, tl, cso;
    logic [15:0] s;
    f = eth_head(efv_pkg::ETH_IPV4);
    o = 14 + ihl * 4;
    tl = ihl * 4 + seg;
    for (int k = 14; k < o + seg + pad; k++) f = {f, 8'($urandom)};
    f[14] = {4'd4, 4'(ihl)};
    f[16] = tl[15:8]; f[17] = tl[7:0];
    f[23] = prot;
    f[24] = 8'h00; f[25] = 8'h00;
    s = sum_words(f, 14, ihl * 4);
    f[24] = 8'(~s >> 8); f[25] = 8'(~s);
    if (prot == efv_pkg::PROT_TCP && seg >= 20) begin
      f[o+12] = {4'($urandom_range(5, 5 + (seg - 20) / 4 > 15 ? 15 : 5 + (seg - 20) / 4)),
                 f[o+12][3:0]};
      cso = o + 16;
    end else if (prot == efv_pkg::PROT_UDP && seg >= 8) begin
      f[o+4] = seg[15:8]; f[o+5] = seg[7:0];
      cso = o + 6;
    end else cso = -1;
    if (cso >= 0) begin
      f[cso] = 8'h00; f[cso+1] = 8'h00;
      s = ones_add(sum_words(f, 26, 8), 16'(prot));
      s = ones_add(s, 16'(seg));
      s = ones_add(s, sum_words(f, o, seg));
      f[cso] = 8'(~s >> 8); f[cso+1] = 8'(~s);
      if (zero_udp_csum) begin f[cso] = 8'h00; f[cso+1] = 8'h00; end
    end
    return f;
  endfunction

  task automatic queue_frame(frame_t f, bit marked = 1);
    byte_t bt;
    foreach (f[k]) begin
      bt.data = f[k];
      bt.last = marked && (k == f.size() - 1);
      byte_q = {byte_q, bt};
    end
  endtask

  function automatic frame_t random_good();
    case ($urandom_range(0, 3))
      0: return arp_frame(16'($urandom_range(1, 2)), $urandom_range(0, 3) == 0);
      1: return ip_frame(efv_pkg::PROT_TCP, $urandom_range(5, 7), $urandom_range(20, 60),
                         $urandom_range(0, 3), 0);
      2: return ip_frame(efv_pkg::PROT_UDP, $urandom_range(5, 7), $urandom_range(8, 50),
                         $urandom_range(0, 3), $urandom_range(0, 4) == 0);
      default: return ip_frame(8'($urandom), 5, $urandom_range(0, 30), 1, 0);
    endcase
  endfunction

  // ---------------- driver: inputs move on the falling edge ----------------
  // byte transaction seen at the rising edge, before the block updates full
  always @(posedge clk) in_acc <= rst_n && push_r && !full_w;

  int gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      push_r <= 0; data_r <= 0; last_r <= 0;
    end else begin
      if (in_acc) begin
        predict_byte(data_r, last_r);
        bytes_sent++;
        void'(byte_q.pop_front());
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 6) : 0;
      end
      if (gap > 0 || sender_hold || byte_q.size() == 0) begin
        if (gap > 0) gap--;
        push_r <= 0;
      end else begin
        push_r <= 1;
        data_r <= byte_q[0].data;
        last_r <= byte_q[0].last;
      end
    end
  end

  // ---------------- monitor: sample at rising edge, pop at falling ----------------
  int pop_gap = 0;
  always @(posedge clk) begin
    verdict_t e;
    if (rst_n && pop_r && !empty_w) begin
      frames_seen++;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected status transaction %0d", status_w);
      end else begin
        e = verdict_q.pop_front();
        if (status_w !== e.status || kind_w !== e.kind || len_w !== e.len) begin
          mismatches++;
          if (mismatches <= 10)
            $display("frame %0d: expected st=%0d kind=%0d len=%0d got st=%0d kind=%0d len=%0d",
                     frames_seen, e.status, e.kind, e.len, status_w, kind_w, len_w);
        end
      end
      pop_gap <= $urandom_range(0, 2) == 0 ? $urandom_range(0, 6) : 0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) pop_r <= 0;
    else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      pop_r <= 0;
    end else if (pop_gap > 0 && !(pop_r && !empty_w)) begin
      pop_gap <= pop_gap - 1;
      pop_r <= 0;
    end else pop_r <= !(pop_r && !empty_w && pop_gap > 0);
  end

  task automatic drain();
    while (byte_q.size() > 0 || verdict_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // ---------------- stimulus ----------------
  initial begin
    frame_t f;
    rst_n = 0;
    clear_parse();
    push_r = 0; data_r = 0; last_r = 0; pop_r = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;

    // directed corners: short frames, foreign ethertype, arp faults and bcast
    f = eth_head(efv_pkg::ETH_IPV4); f = f[0:12]; queue_frame(f);
    f = {8'hFF}; queue_frame(f);
    f = eth_head(16'h86DD); queue_frame(f);
    queue_frame(eth_head(efv_pkg::ETH_ARP));
    queue_frame(arp_frame(16'd1, 0));
    queue_frame(arp_frame(16'd2, 1));
    f = arp_frame(16'd3, 0); queue_frame(f);
    f = arp_frame(16'd1, 0); f[15] = 8'h02; queue_frame(f);
    f = arp_frame(16'd1, 0); f[17] = 8'h06; queue_frame(f);
    f = arp_frame(16'd1, 0); f[18] = 8'd8; queue_frame(f);
    f = arp_frame(16'd1, 0); f[19] = 8'd16; queue_frame(f);
    f = arp_frame(16'd1, 0); f = f[0:30]; queue_frame(f);
    // ipv4 corners
    f = ip_frame(efv_pkg::PROT_TCP, 5, 20, 0, 0); f = f[0:30]; queue_frame(f);
    f = ip_frame(efv_pkg::PROT_TCP, 5, 20, 0, 0); f[14] = 8'h65; queue_frame(f);
    f = ip_frame(efv_pkg::PROT_TCP, 5, 20, 0, 0); f[14] = 8'h44; queue_frame(f);
    f = ip_frame(efv_pkg::PROT_TCP, 15, 20, 0, 0); f = f[0:50]; queue_frame(f);
    f = ip_frame(efv_pkg::PROT_TCP, 5, 20, 0, 0); f[17] = 8'd4; f[16] = 8'h00;
    queue_frame(f);
    f = ip_frame(efv_pkg::PROT_TCP, 5, 20, 0, 0); f[16] = 8'hFF; queue_frame(f);
    f = ip_frame(efv_pkg::PROT_TCP, 5, 20, 0, 0); f[25] = ~f[25]; queue_frame(f);
    queue_frame(ip_frame(8'd1, 5, 8, 0, 0));
    queue_frame(ip_frame(efv_pkg::PROT_TCP, 5, 10, 0, 0));
    f = ip_frame(efv_pkg::PROT_TCP, 5, 21, 0, 0); f[46] = 8'h40; queue_frame(f);
    f = ip_frame(efv_pkg::PROT_TCP, 5, 21, 0, 0); f[46] = 8'hF0; queue_frame(f);
    f = ip_frame(efv_pkg::PROT_TCP, 6, 33, 0, 0); f[f.size()-1] ^= 8'h01; queue_frame(f);
    queue_frame(ip_frame(efv_pkg::PROT_UDP, 5, 4, 0, 0));
    f = ip_frame(efv_pkg::PROT_UDP, 5, 9, 0, 0); f[39] = 8'd3; queue_frame(f);
    f = ip_frame(efv_pkg::PROT_UDP, 5, 9, 0, 0); f[39] = 8'd200; queue_frame(f);
    f = ip_frame(efv_pkg::PROT_UDP, 5, 13, 0, 0); f[f.size()-1] ^= 8'h80; queue_frame(f);
    queue_frame(ip_frame(efv_pkg::PROT_UDP, 5, 13, 2, 1));
    // unmarked frame merges into the next one
    queue_frame(ip_frame(efv_pkg::PROT_TCP, 5, 20, 0, 0), 0);
    queue_frame(ip_frame(efv_pkg::PROT_UDP, 5, 8, 0, 0));
    drain();

    // sender goes on while the receiver holds off, so the block backs up
    hold_off_cycles = 1500;
    for (int k = 0; k < 10; k++) queue_frame(ip_frame(efv_pkg::PROT_UDP, 5, 8, 0, 0));
    drain();

    // random part: mostly well-formed frames, some corrupted, some noise
    while (bytes_sent < 2400 && frames_seen < 1000) begin
      if (byte_q.size() > 200) @(posedge clk);
      else begin
        f = random_good();
        case ($urandom_range(0, 9))
          0: f[$urandom_range(0, f.size() - 1)] = 8'($urandom);
          1: f = f[0:$urandom_range(0, f.size() - 1)];
          2: begin
            f.delete();
            repeat ($urandom_range(1, 60)) f = {f, 8'($urandom)};
          end
          default: ;
        endcase
        queue_frame(f);
        // now and then the sender waits for every pending status
        if ($urandom_range(0, 4) == 0) begin
          sender_hold = 1;
          while (verdict_q.size() > 0) @(posedge clk);
          sender_hold = 0;
        end
      end
    end
    drain();
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    $display("covered %0d frames over %0d bytes: arp, ipv4, tcp, udp, errors", frames_seen,
             bytes_sent);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("timeout");
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
